>>> rtl/a4s_pkg.sv
// ----------------------------------------------------------------------------
// a4s_pkg
// shared types, codes and constants of the four-dimensional cell store
// ----------------------------------------------------------------------------
package a4s_pkg;

	localparam int CELL_CAPACITY_DEF = 4096;
	localparam int DATA_BITS_DEF     = 32;

	localparam int DIM_W     = 13;
	localparam int COORD_W   = 16;
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 13;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	localparam logic [DIM_W-1:0] DIM_X_RST = 13'd16;
	localparam logic [DIM_W-1:0] DIM_Y_RST = 13'd16;
	localparam logic [DIM_W-1:0] DIM_Z_RST = 13'd4;
	localparam logic [DIM_W-1:0] DIM_T_RST = 13'd4;

	localparam logic [1:0] REG_DIM_X = 2'd0;
	localparam logic [1:0] REG_DIM_Y = 2'd1;
	localparam logic [1:0] REG_DIM_Z = 2'd2;
	localparam logic [1:0] REG_DIM_T = 2'd3;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]                operation;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic signed [COORD_W-1:0] coord_t;
		logic [VAL_W-1:0]          write_value;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [VAL_W-1:0]     read_data;
		logic                 present;
		logic [CNT_OUT_W-1:0] absent_cnt;
		logic [CNT_OUT_W-1:0] used_cnt;
	} rsp_t;

	typedef struct packed {
		logic first;
		logic base_one;
		logic en;
	} mac_ctrl_t;

	typedef struct packed {
		logic store_we;
		logic pres_we;
		logic pres_bit;
	} mem_ctrl_t;

	function automatic logic coord_in_dim(logic signed [COORD_W-1:0] c, logic [DIM_W-1:0] d);
		logic [COORD_W-2:0] mag;
		logic [COORD_W-2:0] lim;
		mag = c[COORD_W-2:0];
		lim = (COORD_W-1)'(d);
		return !c[COORD_W-1] && (mag < lim);
	endfunction

endpackage

>>> rtl/a4s_mac.sv
// ----------------------------------------------------------------------------
// a4s_mac
// shared saturating multiply-add step: acc = acc * dim + addend
// ----------------------------------------------------------------------------
module a4s_mac
	import a4s_pkg::*;
#(
	parameter int CELL_CAPACITY = CELL_CAPACITY_DEF,
	parameter int ACC_W         = $clog2(CELL_CAPACITY + 1)
) (
	input  logic             clk,
	input  mac_ctrl_t        ctrl,
	input  logic [DIM_W-1:0] dim,
	input  logic [DIM_W-1:0] addend,
	output logic [ACC_W-1:0] acc,
	output logic [ACC_W-1:0] nxt
);

	localparam int PROD_W = ACC_W + DIM_W;
	localparam int SUM_W  = PROD_W + 1;

	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  base;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  sum;

	// saturation at capacity is exact, every later step with a nonzero dim only grows
	always_comb begin
		if (ctrl.first) begin
			base = ctrl.base_one ? ACC_W'(1) : '0;
		end else begin
			base = acc_q;
		end
		prod = PROD_W'(base) * PROD_W'(dim);
		sum  = SUM_W'(prod) + SUM_W'(addend);
		nxt  = (sum >= SUM_W'(CELL_CAPACITY)) ? ACC_W'(CELL_CAPACITY) : sum[ACC_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= nxt;
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/a4s_mem.sv
// ----------------------------------------------------------------------------
// a4s_mem
// cell store and presence bit memories, one write and one registered read
// ----------------------------------------------------------------------------
module a4s_mem
	import a4s_pkg::*;
#(
	parameter int CELL_CAPACITY = CELL_CAPACITY_DEF,
	parameter int DATA_BITS     = DATA_BITS_DEF,
	parameter int ADDR_W        = $clog2(CELL_CAPACITY)
) (
	input  logic                 clk,
	input  mem_ctrl_t            ctrl,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic [ADDR_W-1:0]    rd_addr,
	output logic [DATA_BITS-1:0] rd_data,
	output logic                 rd_pres
);

	logic [DATA_BITS-1:0] store_mem [CELL_CAPACITY];
	logic                 pres_mem  [CELL_CAPACITY];
	logic [DATA_BITS-1:0] rd_data_q;
	logic                 rd_pres_q;

	always_ff @(posedge clk) begin
		if (ctrl.store_we) begin
			store_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.pres_we) begin
			pres_mem[wr_addr] <= ctrl.pres_bit;
		end
		rd_pres_q <= pres_mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign rd_pres = rd_pres_q;

endmodule

>>> rtl/array4d_store_with_presence.sv
// ----------------------------------------------------------------------------
// array4d_store_with_presence
// four-dimensional cell store with per-cell presence bits and missing count
// ----------------------------------------------------------------------------
// Each request passes from acceptance through four multiply-add steps of the
// shared index unit (t, z, y, x), the registered memory read and then the
// response and write-back, where it holds while the output is stalled; no new
// request is accepted before it is through. The response waits in an output
// register while the next request is taken. After reset and after every
// dimension register write the block recomputes the cell total on the same
// unit and then sweeps the whole presence memory, one cell a cycle, accepting
// no request meanwhile.
// ----------------------------------------------------------------------------
module array4d_store_with_presence
	import a4s_pkg::*;
#(
	parameter int CELL_CAPACITY = CELL_CAPACITY_DEF,
	parameter int DATA_BITS     = DATA_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp
);

	localparam int ACC_W  = $clog2(CELL_CAPACITY + 1);
	localparam int ADDR_W = $clog2(CELL_CAPACITY);

	typedef enum logic [5:0] {
		S_TOTAL = 6'b000001,
		S_CLEAR = 6'b000010,
		S_IDLE  = 6'b000100,
		S_INDEX = 6'b001000,
		S_FETCH = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [1:0]           cnt_q;
	logic [ADDR_W-1:0]    clr_q;
	logic [DIM_W-1:0]     dim_x_q;
	logic [DIM_W-1:0]     dim_y_q;
	logic [DIM_W-1:0]     dim_z_q;
	logic [DIM_W-1:0]     dim_t_q;
	logic [ACC_W-1:0]     total_q;
	logic [ACC_W-1:0]     missing_q;
	logic                 hit_q;
	req_t                 req_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 cfg_wr;
	logic [1:0]           cfg_idx;
	logic                 req_acc;
	logic                 rsp_free;
	logic                 resp_go;
	logic                 coords_ok;
	mac_ctrl_t            mac_ctrl;
	logic [DIM_W-1:0]     mac_dim;
	logic [DIM_W-1:0]     mac_add;
	logic [ACC_W-1:0]     mac_acc;
	logic [ACC_W-1:0]     mac_nxt;
	mem_ctrl_t            mem_ctrl;
	logic [ADDR_W-1:0]    mem_wr_addr;
	logic [ADDR_W-1:0]    mem_rd_addr;
	logic [DATA_BITS-1:0] mem_rd_data;
	logic                 mem_rd_pres;
	logic                 wr_store;
	logic                 wr_pres;
	logic [ACC_W-1:0]     miss_d;
	rsp_t                 rsp_d;

	// configuration port
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[APB_AW-1:2];
	assign pready  = 1'b1;

	always_comb begin
		unique case (cfg_idx)
			REG_DIM_X: prdata = APB_DW'(dim_x_q);
			REG_DIM_Y: prdata = APB_DW'(dim_y_q);
			REG_DIM_Z: prdata = APB_DW'(dim_z_q);
			REG_DIM_T: prdata = APB_DW'(dim_t_q);
			default:   prdata = '0;
		endcase
	end

	// request and response handshakes
	assign req_stall = (state_q != S_IDLE) | cfg_wr;
	assign req_acc   = req_valid & ~req_stall;
	assign rsp_free  = ~rsp_valid_q | ~rsp_stall;
	assign resp_go   = (state_q == S_RESP) & rsp_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign coords_ok = coord_in_dim(req.coord_x, dim_x_q) & coord_in_dim(req.coord_y, dim_y_q)
		& coord_in_dim(req.coord_z, dim_z_q) & coord_in_dim(req.coord_t, dim_t_q);

	// shared unit steps through t, z, y, x
	always_comb begin
		unique case (cnt_q)
			2'd0: begin
				mac_dim = dim_t_q;
				mac_add = req_q.coord_t[DIM_W-1:0];
			end
			2'd1: begin
				mac_dim = dim_z_q;
				mac_add = req_q.coord_z[DIM_W-1:0];
			end
			2'd2: begin
				mac_dim = dim_y_q;
				mac_add = req_q.coord_y[DIM_W-1:0];
			end
			default: begin
				mac_dim = dim_x_q;
				mac_add = req_q.coord_x[DIM_W-1:0];
			end
		endcase
		if (state_q == S_TOTAL) begin
			mac_add = '0;
		end
		mac_ctrl.first    = (cnt_q == 2'd0);
		mac_ctrl.base_one = (state_q == S_TOTAL);
		mac_ctrl.en       = (state_q == S_TOTAL) || (state_q == S_INDEX);
	end

	a4s_mac #(
		.CELL_CAPACITY(CELL_CAPACITY),
		.ACC_W        (ACC_W)
	) u_mac (
		.clk   (clk),
		.ctrl  (mac_ctrl),
		.dim   (mac_dim),
		.addend(mac_add),
		.acc   (mac_acc),
		.nxt   (mac_nxt)
	);

	// response and write-back
	always_comb begin
		rsp_d          = '0;
		wr_store       = 1'b0;
		wr_pres        = 1'b0;
		miss_d         = missing_q;
		rsp_d.used_cnt = CNT_OUT_W'(total_q);
		if (!hit_q) begin
			rsp_d.status = ST_RANGE;
		end else begin
			unique case (req_q.operation)
				OP_WRITE: begin
					rsp_d.present = 1'b1;
					wr_store      = 1'b1;
					if (!mem_rd_pres) begin
						wr_pres = 1'b1;
						if (missing_q != '0) begin
							miss_d = missing_q - ACC_W'(1);
						end
					end
				end
				OP_READ: begin
					if (mem_rd_pres) begin
						rsp_d.read_data = VAL_W'(mem_rd_data);
						rsp_d.present   = 1'b1;
					end else begin
						rsp_d.status = ST_EMPTY;
					end
				end
				default: begin
					rsp_d.present = mem_rd_pres;
				end
			endcase
		end
		rsp_d.absent_cnt = CNT_OUT_W'(miss_d);
	end

	assign mem_rd_addr = mac_acc[ADDR_W-1:0];

	always_comb begin
		mem_ctrl.store_we = resp_go & wr_store;
		mem_ctrl.pres_we  = resp_go & wr_pres;
		mem_ctrl.pres_bit = 1'b1;
		mem_wr_addr       = mem_rd_addr;
		if (state_q == S_CLEAR) begin
			mem_ctrl.pres_we  = 1'b1;
			mem_ctrl.pres_bit = 1'b0;
			mem_wr_addr       = clr_q;
		end
	end

	a4s_mem #(
		.CELL_CAPACITY(CELL_CAPACITY),
		.DATA_BITS    (DATA_BITS),
		.ADDR_W       (ADDR_W)
	) u_mem (
		.clk    (clk),
		.ctrl   (mem_ctrl),
		.wr_addr(mem_wr_addr),
		.wr_data(DATA_BITS'(req_q.write_value)),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data),
		.rd_pres(mem_rd_pres)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_TOTAL;
			cnt_q       <= '0;
			clr_q       <= '0;
			dim_x_q     <= DIM_X_RST;
			dim_y_q     <= DIM_Y_RST;
			dim_z_q     <= DIM_Z_RST;
			dim_t_q     <= DIM_T_RST;
			total_q     <= '0;
			missing_q   <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (resp_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_DIM_X: dim_x_q <= pwdata[DIM_W-1:0];
					REG_DIM_Y: dim_y_q <= pwdata[DIM_W-1:0];
					REG_DIM_Z: dim_z_q <= pwdata[DIM_W-1:0];
					REG_DIM_T: dim_t_q <= pwdata[DIM_W-1:0];
					default:   dim_x_q <= dim_x_q;
				endcase
				state_q <= S_TOTAL;
				cnt_q   <= '0;
				clr_q   <= '0;
			end else begin
				unique case (state_q)
					S_TOTAL: begin
						cnt_q <= cnt_q + 2'd1;
						if (cnt_q == 2'd3) begin
							total_q   <= mac_nxt;
							missing_q <= mac_nxt;
							clr_q     <= '0;
							state_q   <= S_CLEAR;
						end
					end
					S_CLEAR: begin
						clr_q <= clr_q + ADDR_W'(1);
						if (clr_q == ADDR_W'(CELL_CAPACITY - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (req_acc) begin
							hit_q   <= coords_ok;
							cnt_q   <= '0;
							state_q <= S_INDEX;
						end
					end
					S_INDEX: begin
						cnt_q <= cnt_q + 2'd1;
						if (cnt_q == 2'd3) begin
							state_q <= S_FETCH;
						end
					end
					S_FETCH: begin
						hit_q   <= hit_q & (mac_acc < ACC_W'(CELL_CAPACITY));
						state_q <= S_RESP;
					end
					S_RESP: begin
						if (rsp_free) begin
							missing_q <= miss_d;
							state_q   <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req;
		end
		if (resp_go) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_missing_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		missing_q <= total_q)
		else $error("missing count above total");

	a_req_starts_index: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == S_INDEX) && (cnt_q == 2'd0))
		else $error("request did not start index steps");

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (state_q == S_TOTAL) && (cnt_q == 2'd0) && (clr_q == '0))
		else $error("dimension write did not restart total and sweep");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("response raised outside response state");
`endif

endmodule

>>> tb/array4d_store_checker.sv
// ----------------------------------------------------------------------------
// array4d_store_checker
// watches the register port and the request and response channels of the four-dimensional
// cell store, predicts every response from its own copy of the dimensions,
// cell values and presence bits, and compares each accepted response field by
// field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module array4d_store_checker
	import a4s_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              req_valid,
	input  logic              req_stall,
	input  req_t              req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  rsp_t              rsp,
	output int                mismatches,
	output int                outstanding
);

	localparam int CELLS = CELL_CAPACITY_DEF;

	logic [DIM_W-1:0] dim [4];
	logic [VAL_W-1:0] cell_val [CELLS];
	bit               cell_set [CELLS];
	logic [DIM_W-1:0] cells_left;
	rsp_t             pending_rsp [$];
	int               fail_n = 0;
	int               wait_n = 0;

	assign mismatches  = fail_n;
	assign outstanding = wait_n;

	function automatic longint unsigned live_cells();
		longint unsigned p;
		p = longint'(dim[REG_DIM_X]) * longint'(dim[REG_DIM_Y]) *
			longint'(dim[REG_DIM_Z]) * longint'(dim[REG_DIM_T]);
		return (p > CELLS) ? CELLS : p;
	endfunction

	function automatic bit cell_index(input req_t r, output int unsigned slot);
		longint x, y, z, t;
		longint unsigned idx;
		x = longint'($signed(r.coord_x));
		y = longint'($signed(r.coord_y));
		z = longint'($signed(r.coord_z));
		t = longint'($signed(r.coord_t));
		slot = 0;
		if (x < 0 || x >= longint'(dim[REG_DIM_X]) || y < 0 || y >= longint'(dim[REG_DIM_Y]) ||
			z < 0 || z >= longint'(dim[REG_DIM_Z]) || t < 0 || t >= longint'(dim[REG_DIM_T]))
			return 0;
		idx = ((longint'(t) * dim[REG_DIM_Z] + z) * dim[REG_DIM_Y] + y) * dim[REG_DIM_X] + x;
		if (idx >= live_cells())
			return 0;
		slot = int'(idx);
		return 1;
	endfunction

	task automatic forget_cells();
		for (int i = 0; i < CELLS; i++)
			cell_set[i] = 0;
		cells_left = DIM_W'(live_cells());
	endtask

	task automatic predict_access(input req_t r, output rsp_t e);
		int unsigned slot;
		e = '0;
		if (!cell_index(r, slot)) begin
			e.status = ST_RANGE;
		end else begin
			case (r.operation)
				OP_WRITE: begin
					cell_val[slot] = r.write_value;
					if (!cell_set[slot]) begin
						cell_set[slot] = 1;
						if (cells_left != 0)
							cells_left = cells_left - 1'b1;
					end
					e.present = 1'b1;
				end
				OP_READ: begin
					if (cell_set[slot]) begin
						e.read_data = cell_val[slot];
						e.present   = 1'b1;
					end else begin
						e.status = ST_EMPTY;
					end
				end
				default: e.present = cell_set[slot];
			endcase
		end
		e.absent_cnt = CNT_OUT_W'(cells_left);
		e.used_cnt   = CNT_OUT_W'(live_cells());
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t e;
		rsp_t want;
		if (!arst_n) begin
			dim[REG_DIM_X] = DIM_X_RST;
			dim[REG_DIM_Y] = DIM_Y_RST;
			dim[REG_DIM_Z] = DIM_Z_RST;
			dim[REG_DIM_T] = DIM_T_RST;
			forget_cells();
			pending_rsp.delete();
			wait_n = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				dim[paddr[APB_AW-1:2]] = pwdata[DIM_W-1:0];
				forget_cells();
			end
			if (req_valid && !req_stall) begin
				predict_access(req, e);
				pending_rsp.push_back(e);
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					fail_n++;
					if (fail_n <= 10)
						$display("%0t: response with no request waiting: status %0d data %h",
							$realtime, rsp.status, rsp.read_data);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.status !== want.status || rsp.read_data !== want.read_data ||
						rsp.present !== want.present ||
						rsp.absent_cnt !== want.absent_cnt ||
						rsp.used_cnt !== want.used_cnt) begin
						fail_n++;
						if (fail_n <= 10) begin
							$display("%0t: expected status %0d data %h present %0b missing %0d total %0d",
								$realtime, want.status, want.read_data, want.present,
								want.absent_cnt, want.used_cnt);
							$display("%0t: actual   status %0d data %h present %0b missing %0d total %0d",
								$realtime, rsp.status, rsp.read_data, rsp.present,
								rsp.absent_cnt, rsp.used_cnt);
						end
					end
				end
			end
			wait_n = pending_rsp.size();
		end
	end

endmodule

>>> tb/array4d_store_with_presence_test.sv
// ----------------------------------------------------------------------------
// array4d_store_with_presence_test
// drives directed and random write, read and presence requests into the cell
// store across several dimension settings, zero, one and the largest among
// them, with random gaps on both channels; the checker beside the block
// predicts and compares every response
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module array4d_store_with_presence_test;
	import a4s_pkg::*;

	localparam int         ITEMS_TOTAL    = 1855;
	localparam int         SWEEP_WAIT     = 4 + CELL_CAPACITY_DEF + 12;
	localparam int         DRAIN_WAIT     = 16;
	localparam int         STALL_LIMIT    = 20000;
	localparam logic [1:0] OP_ALIAS_QUERY = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              req_valid;
	logic              req_stall;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_t              rsp;
	int                mismatches;
	int                outstanding;

	int               sent_n = 0;
	int               idle_cycles = 0;
	int               send_idle_pct = 33;
	int               recv_idle_pct = 69;
	logic [DIM_W-1:0] dims [4];
	bit               ever_written [CELL_CAPACITY_DEF];
	int unsigned      written_now [$];

	array4d_store_with_presence dut (.*);

	array4d_store_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk)
		rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic longint unsigned total_of_dims();
		longint unsigned p;
		p = longint'(dims[REG_DIM_X]) * longint'(dims[REG_DIM_Y]) *
			longint'(dims[REG_DIM_Z]) * longint'(dims[REG_DIM_T]);
		return (p > CELL_CAPACITY_DEF) ? CELL_CAPACITY_DEF : p;
	endfunction

	function automatic bit cell_hit(input req_t r, output int unsigned slot);
		longint x, y, z, t;
		longint unsigned idx;
		x = longint'($signed(r.coord_x));
		y = longint'($signed(r.coord_y));
		z = longint'($signed(r.coord_z));
		t = longint'($signed(r.coord_t));
		slot = 0;
		if (x < 0 || x >= longint'(dims[REG_DIM_X]) || y < 0 || y >= longint'(dims[REG_DIM_Y]) ||
			z < 0 || z >= longint'(dims[REG_DIM_Z]) || t < 0 || t >= longint'(dims[REG_DIM_T]))
			return 0;
		idx = ((longint'(t) * dims[REG_DIM_Z] + z) * dims[REG_DIM_Y] + y) * dims[REG_DIM_X] + x;
		if (idx >= total_of_dims())
			return 0;
		slot = int'(idx);
		return 1;
	endfunction

	function automatic req_t make_req(input logic [1:0] op, input int x, input int y,
		input int z, input int t, input logic [VAL_W-1:0] v);
		req_t r;
		r.operation   = op;
		r.coord_x     = COORD_W'(x);
		r.coord_y     = COORD_W'(y);
		r.coord_z     = COORD_W'(z);
		r.coord_t     = COORD_W'(t);
		r.write_value = v;
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] border_coord(input logic [DIM_W-1:0] d);
		case ($urandom_range(0, 4))
			0: return '1;
			1: return '0;
			2: return COORD_W'(d) - 1'b1;
			3: return COORD_W'(d);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic req_t random_req();
		req_t r;
		longint unsigned total;
		int unsigned idx, rem;
		int pick, opk;
		total = total_of_dims();
		opk   = $urandom_range(0, 99);
		pick  = $urandom_range(0, 99);
		r.operation   = (opk < 40) ? OP_WRITE : (opk < 75) ? OP_READ :
			(opk < 90) ? OP_QUERY : OP_ALIAS_QUERY;
		r.write_value = $urandom;
		if (total != 0 && pick < 80) begin
			if (r.operation != OP_WRITE && written_now.size() != 0 && $urandom_range(0, 99) < 70)
				idx = written_now[$urandom_range(0, written_now.size() - 1)];
			else
				idx = $urandom_range(0, int'(total - 1));
			rem = idx;
			r.coord_x = COORD_W'(rem % dims[REG_DIM_X]);
			rem       = rem / dims[REG_DIM_X];
			r.coord_y = COORD_W'(rem % dims[REG_DIM_Y]);
			rem       = rem / dims[REG_DIM_Y];
			r.coord_z = COORD_W'(rem % dims[REG_DIM_Z]);
			r.coord_t = COORD_W'(rem / dims[REG_DIM_Z]);
		end else if (pick < 90) begin
			r.coord_x = border_coord(dims[REG_DIM_X]);
			r.coord_y = border_coord(dims[REG_DIM_Y]);
			r.coord_z = border_coord(dims[REG_DIM_Z]);
			r.coord_t = border_coord(dims[REG_DIM_T]);
		end else begin
			r.coord_x = COORD_W'($urandom);
			r.coord_y = COORD_W'($urandom);
			r.coord_z = COORD_W'($urandom);
			r.coord_t = COORD_W'($urandom);
		end
		return r;
	endfunction

	// called just after a falling edge, returns just after one
	task automatic send_req(input req_t item);
		int unsigned slot;
		bit hit;
		hit = cell_hit(item, slot);
		// never read a cell whose store word was never filled
		if (hit && item.operation == OP_READ && !ever_written[slot])
			item.operation = OP_WRITE;
		if (hit && item.operation == OP_WRITE) begin
			ever_written[slot] = 1;
			written_now.push_back(slot);
		end
		if (sent_n < ITEMS_TOTAL / 3) begin
			send_idle_pct = 33;
			recv_idle_pct = 69;
		end else if (sent_n < 2 * ITEMS_TOTAL / 3) begin
			send_idle_pct = 69;
			recv_idle_pct = 33;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req       = item;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		sent_n++;
	endtask

	task automatic reg_write(input logic [1:0] reg_id, input logic [DIM_W-1:0] val);
		logic [APB_DW-1:0] w;
		w              = $urandom;
		w[DIM_W-1:0]   = val;
		// the block sweeps its presence bits after reset and every dimension write
		repeat (SWEEP_WAIT) @(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = APB_AW'({reg_id, 2'b00});
		pwdata  = w;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		dims[reg_id] = val;
	endtask

	task automatic run_phase(input int dx, input int dy, input int dz, input int dt, input int n);
		req_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		reg_write(REG_DIM_X, DIM_W'(dx));
		reg_write(REG_DIM_Y, DIM_W'(dy));
		reg_write(REG_DIM_Z, DIM_W'(dz));
		reg_write(REG_DIM_T, DIM_W'(dt));
		written_now.delete();
		// cell zero was filled earlier, so its presence has just been cleared
		send_req(make_req(OP_READ, 0, 0, 0, 0, $urandom));
		repeat (n)
			send_req(random_req());
	endtask

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_valid = 1'b0;
		req       = '0;
		dims[REG_DIM_X] = DIM_X_RST;
		dims[REG_DIM_Y] = DIM_Y_RST;
		dims[REG_DIM_Z] = DIM_Z_RST;
		dims[REG_DIM_T] = DIM_T_RST;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		send_req(make_req(OP_QUERY, 0, 0, 0, 0, 32'h0000_0000));
		send_req(make_req(OP_WRITE, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send_req(make_req(OP_READ, 0, 0, 0, 0, 32'h0000_0000));
		send_req(make_req(OP_WRITE, 15, 15, 3, 3, 32'h0000_0000));
		send_req(make_req(OP_READ, 15, 15, 3, 3, 32'hFFFF_FFFF));
		send_req(make_req(OP_WRITE, 0, 0, 0, 0, 32'hA5A5_5A5A));
		send_req(make_req(OP_READ, 0, 0, 0, 0, 32'h0000_0000));
		send_req(make_req(OP_QUERY, 15, 15, 3, 3, 32'h0000_0000));
		send_req(make_req(OP_ALIAS_QUERY, 15, 15, 3, 3, 32'h0000_0000));
		send_req(make_req(OP_ALIAS_QUERY, 1, 0, 0, 0, 32'h0000_0000));
		send_req(make_req(OP_WRITE, -1, 0, 0, 0, 32'h1234_5678));
		send_req(make_req(OP_READ, 16, 0, 0, 0, 32'h0000_0000));
		send_req(make_req(OP_QUERY, 0, 16, 0, 0, 32'h0000_0000));
		send_req(make_req(OP_WRITE, 0, 0, 4, 0, 32'hFFFF_FFFF));
		send_req(make_req(OP_READ, 0, 0, 0, 4, 32'h0000_0000));
		send_req(make_req(OP_READ, -32768, -32768, -32768, -32768, 32'hFFFF_FFFF));
		send_req(make_req(OP_WRITE, 32767, 32767, 32767, 32767, 32'h5A5A_A5A5));
		send_req(make_req(OP_ALIAS_QUERY, 0, 0, 0, -1, 32'h0000_0000));
		repeat (300)
			send_req(random_req());

		run_phase(1, 1, 1, 1, 120);
		run_phase(4096, 8191, 4096, 4096, 250);
		run_phase(0, 5, 3, 2, 100);
		run_phase(64, 64, 1, 1, 300);
		run_phase(7, 5, 3, 2, 330);
		run_phase(3, 2, 2, 1, 150);
		run_phase($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
			$urandom_range(1, 12), 280);

		req_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/a4s_pkg.sv
rtl/a4s_mac.sv
rtl/a4s_mem.sv
rtl/array4d_store_with_presence.sv
tb/array4d_store_checker.sv
tb/array4d_store_with_presence_test.sv
